/* hdl/msqrt_pkg.sv */
// Package with constants and types shared by the modular square root block.
package msqrt_pkg;

    localparam int unsigned Width    = 62;
    localparam int unsigned CntW     = 7;
    localparam int unsigned IdxW     = 1;

    localparam logic [Width-1:0] ModulusReset    = 62'h3FFF_FFFF_FFFF_0001;
    localparam logic [Width-1:0] NonresidueReset = 62'd7;

    localparam logic [IdxW-1:0] RegModulus    = 1'b0;
    localparam logic [IdxW-1:0] RegNonresidue = 1'b1;

    // States of the request sequencer.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_VAL,
        ST_RED_GEN,
        ST_LEG_INIT,
        ST_LEG_MUL,
        ST_LEG_SQ,
        ST_LEG_CHK,
        ST_FB_MUL,
        ST_TS_ZERO,
        ST_TS_C_MUL,
        ST_TS_C_SQ,
        ST_TS_T_MUL,
        ST_TS_T_SQ,
        ST_TS_R_MUL,
        ST_TS_R_SQ,
        ST_LOOP_CHK,
        ST_FIND_SQ,
        ST_B_SQ,
        ST_C_SQ,
        ST_T_MUL,
        ST_R_MUL,
        ST_VERIFY,
        ST_FINISH,
        ST_OUT
    } t_state;

endpackage

/* hdl/modular_square_root_with_fallback_core.sv */
// Top level of the modular square root block with non-residue fallback.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-----------------------------------
//  request   | in  | s_axis_tvalid/ready | tdata[61:0] value
//  result    | out | m_axis_tvalid/ready | tdata[61:0] root, tuser was_residue
//  config    | in  | i_cfg_we            | i_cfg_idx, i_cfg_data[61:0]
//
// One request is worked on at a time. All products go through one
// bit-serial modular multiplier, which runs the same steps (issue, bit
// steps, return) whatever the modulus; the number of products a request
// costs is set by the exponent lengths of the Legendre power and of the
// Tonelli-Shanks loop. Input reduction is a restoring subtract, one
// quotient bit per cycle, first for the value and then for the non-residue.
// Reset is synchronous and active low; it clears the sequencer and restores
// the register defaults. A stalled result holds in its output register and
// the next request is taken only once the result has been delivered.
module modular_square_root_with_fallback_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // [61:0] value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // [61:0] root
    output logic                          m_axis_tuser,  // [0] was_residue
    input  logic                          i_cfg_we,
    input  logic [msqrt_pkg::IdxW-1:0]    i_cfg_idx,
    input  logic [msqrt_pkg::Width-1:0]   i_cfg_data
);

    localparam int unsigned W  = msqrt_pkg::Width;
    localparam int unsigned CW = msqrt_pkg::CntW;

    msqrt_pkg::t_state r_state, n_state;

    logic [W-1:0] r_mod, r_nr;
    logic [W-1:0] r_a, n_a;        // operand (reduced value, later TS operand)
    logic [W-1:0] r_gen, n_gen;
    logic [W-1:0] r_acc, n_acc;    // power accumulator / general scratch
    logic [W-1:0] r_sq, n_sq;      // squaring base
    logic [W-1:0] r_exp, n_exp;    // exponent shift register
    logic [W-1:0] r_c, n_c;
    logic [W-1:0] r_t, n_t;
    logic [W-1:0] r_r, n_r;
    logic [W-1:0] r_b, n_b;
    logic [W-1:0] r_q, n_q;        // odd part of p-1
    logic [W:0]   r_rem, n_rem;    // restoring reduction remainder
    logic [W-1:0] r_div, n_div;    // dividend bits shifted in
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_m, n_m;       // Tonelli-Shanks exponent counter
    logic [CW-1:0] r_i, n_i;
    logic         r_qr, n_qr;
    logic         r_fail, n_fail;
    logic [W-1:0] r_root, n_root;
    logic         r_res, n_res;

    logic         w_start;
    logic [W-1:0] w_x, w_y;
    logic         w_done;
    logic [W-1:0] w_prod;
    logic         w_accept, w_mod_ok;
    logic [W:0]   w_rem_sh, w_rem_sub;
    logic [W-1:0] w_one;
    logic [W-1:0] w_pm1;
    logic [CW-1:0] w_s;
    logic [W-1:0] w_pr;

    assign w_one    = W'(1);
    assign w_pm1    = r_mod - w_one;
    assign w_mod_ok = r_mod[0] && (r_mod != w_one);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_pr     = r_mod - r_r;

    // Restoring reduction step.
    assign w_rem_sh  = {r_rem[W-1:0], r_div[W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_mod};

    // Trailing zero count of p-1 (p odd): the lowest set bit above bit 0 wins.
    always_comb begin
        w_s = '0;
        for (int k = W - 1; k >= 1; k--) begin
            if (w_pm1[k]) begin
                w_s = CW'(k);
            end
        end
    end

    msqrt_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_m     (r_mod),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= msqrt_pkg::ModulusReset;
            r_nr  <= msqrt_pkg::NonresidueReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msqrt_pkg::RegModulus:    r_mod <= i_cfg_data;
                msqrt_pkg::RegNonresidue: r_nr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Multiplier operand selection and start strobes.
    always_comb begin
        w_start = 1'b0;
        w_x     = r_acc;
        w_y     = r_sq;
        unique case (r_state)
            msqrt_pkg::ST_LEG_MUL, msqrt_pkg::ST_TS_C_MUL, msqrt_pkg::ST_TS_T_MUL,
            msqrt_pkg::ST_TS_R_MUL: begin
                w_x = r_acc; w_y = r_sq;
            end
            msqrt_pkg::ST_LEG_SQ, msqrt_pkg::ST_TS_C_SQ, msqrt_pkg::ST_TS_T_SQ,
            msqrt_pkg::ST_TS_R_SQ: begin
                w_x = r_sq; w_y = r_sq;
            end
            msqrt_pkg::ST_FB_MUL:  begin w_x = r_a;  w_y = r_gen; end
            msqrt_pkg::ST_FIND_SQ: begin w_x = r_acc; w_y = r_acc; end
            msqrt_pkg::ST_B_SQ, msqrt_pkg::ST_C_SQ: begin w_x = r_b; w_y = r_b; end
            msqrt_pkg::ST_T_MUL:   begin w_x = r_t;  w_y = r_c; end
            msqrt_pkg::ST_R_MUL:   begin w_x = r_r;  w_y = r_b; end
            msqrt_pkg::ST_VERIFY:  begin w_x = r_r;  w_y = r_r; end
            default: ;
        endcase
        // r_cnt bit CW-1 marks "product in flight".
        if (!r_cnt[CW-1]) begin
            unique case (r_state)
                msqrt_pkg::ST_LEG_MUL, msqrt_pkg::ST_TS_C_MUL, msqrt_pkg::ST_TS_T_MUL,
                msqrt_pkg::ST_TS_R_MUL, msqrt_pkg::ST_LEG_SQ, msqrt_pkg::ST_TS_C_SQ,
                msqrt_pkg::ST_TS_T_SQ, msqrt_pkg::ST_TS_R_SQ, msqrt_pkg::ST_FB_MUL,
                msqrt_pkg::ST_FIND_SQ, msqrt_pkg::ST_B_SQ, msqrt_pkg::ST_C_SQ,
                msqrt_pkg::ST_T_MUL, msqrt_pkg::ST_R_MUL, msqrt_pkg::ST_VERIFY:
                    w_start = 1'b1;
                default: ;
            endcase
        end
    end

    // Next-state and datapath sequencing.
    always_comb begin
        n_state = r_state;
        n_a = r_a; n_gen = r_gen; n_acc = r_acc; n_sq = r_sq; n_exp = r_exp;
        n_c = r_c; n_t = r_t; n_r = r_r; n_b = r_b; n_q = r_q;
        n_rem = r_rem; n_div = r_div; n_cnt = r_cnt; n_m = r_m; n_i = r_i;
        n_qr = r_qr; n_fail = r_fail; n_root = r_root; n_res = r_res;
        if (w_start) begin
            n_cnt = {1'b1, r_cnt[CW-2:0]};
        end
        unique case (r_state)
            msqrt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_root = '0; n_res = 1'b0;
                    if (!w_mod_ok) begin
                        n_state = msqrt_pkg::ST_OUT;
                    end else begin
                        n_div = s_axis_tdata[W-1:0];
                        n_rem = '0; n_cnt = CW'(W);
                        n_state = msqrt_pkg::ST_RED_VAL;
                    end
                end
            end
            msqrt_pkg::ST_RED_VAL, msqrt_pkg::ST_RED_GEN: begin
                n_rem = w_rem_sub[W] ? w_rem_sh : w_rem_sub;
                n_div = {r_div[W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_cnt = '0;
                    if (r_state == msqrt_pkg::ST_RED_VAL) begin
                        n_a = n_rem[W-1:0];
                        n_div = r_nr; n_rem = '0; n_cnt = CW'(W);
                        n_state = msqrt_pkg::ST_RED_GEN;
                    end else begin
                        n_gen = n_rem[W-1:0];
                        n_state = msqrt_pkg::ST_LEG_INIT;
                    end
                end
            end
            msqrt_pkg::ST_LEG_INIT: begin
                n_acc = w_one; n_sq = r_a; n_exp = {1'b0, w_pm1[W-1:1]};
                n_state = msqrt_pkg::ST_LEG_MUL;
            end
            msqrt_pkg::ST_LEG_MUL, msqrt_pkg::ST_TS_C_MUL, msqrt_pkg::ST_TS_T_MUL,
            msqrt_pkg::ST_TS_R_MUL: begin
                if (r_exp == '0) begin
                    n_cnt = '0;
                    unique case (r_state)
                        msqrt_pkg::ST_LEG_MUL:  n_state = msqrt_pkg::ST_LEG_CHK;
                        msqrt_pkg::ST_TS_C_MUL: begin
                            n_c = r_acc; n_acc = w_one; n_sq = r_a; n_exp = r_q;
                            n_state = msqrt_pkg::ST_TS_T_MUL;
                        end
                        msqrt_pkg::ST_TS_T_MUL: begin
                            n_t = r_acc; n_acc = w_one; n_sq = r_a;
                            n_exp = (r_q >> 1) + w_one;
                            n_state = msqrt_pkg::ST_TS_R_MUL;
                        end
                        default: begin
                            n_r = r_acc;
                            n_state = msqrt_pkg::ST_LOOP_CHK;
                        end
                    endcase
                end else if (!r_exp[0]) begin
                    n_cnt = '0;
                    unique case (r_state)
                        msqrt_pkg::ST_LEG_MUL:  n_state = msqrt_pkg::ST_LEG_SQ;
                        msqrt_pkg::ST_TS_C_MUL: n_state = msqrt_pkg::ST_TS_C_SQ;
                        msqrt_pkg::ST_TS_T_MUL: n_state = msqrt_pkg::ST_TS_T_SQ;
                        default:                n_state = msqrt_pkg::ST_TS_R_SQ;
                    endcase
                end else if (w_done) begin
                    n_acc = w_prod; n_cnt = '0;
                    unique case (r_state)
                        msqrt_pkg::ST_LEG_MUL:  n_state = msqrt_pkg::ST_LEG_SQ;
                        msqrt_pkg::ST_TS_C_MUL: n_state = msqrt_pkg::ST_TS_C_SQ;
                        msqrt_pkg::ST_TS_T_MUL: n_state = msqrt_pkg::ST_TS_T_SQ;
                        default:                n_state = msqrt_pkg::ST_TS_R_SQ;
                    endcase
                end
            end
            msqrt_pkg::ST_LEG_SQ, msqrt_pkg::ST_TS_C_SQ, msqrt_pkg::ST_TS_T_SQ,
            msqrt_pkg::ST_TS_R_SQ: begin
                if (w_done) begin
                    n_sq = w_prod; n_exp = r_exp >> 1; n_cnt = '0;
                    unique case (r_state)
                        msqrt_pkg::ST_LEG_SQ:  n_state = msqrt_pkg::ST_LEG_MUL;
                        msqrt_pkg::ST_TS_C_SQ: n_state = msqrt_pkg::ST_TS_C_MUL;
                        msqrt_pkg::ST_TS_T_SQ: n_state = msqrt_pkg::ST_TS_T_MUL;
                        default:               n_state = msqrt_pkg::ST_TS_R_MUL;
                    endcase
                end
            end
            msqrt_pkg::ST_LEG_CHK: begin
                n_qr = (r_acc == w_one);
                n_state = (r_acc == w_one) ? msqrt_pkg::ST_TS_ZERO
                                           : msqrt_pkg::ST_FB_MUL;
            end
            msqrt_pkg::ST_FB_MUL: begin
                if (w_done) begin
                    n_a = w_prod; n_cnt = '0;
                    n_state = msqrt_pkg::ST_TS_ZERO;
                end
            end
            msqrt_pkg::ST_TS_ZERO: begin
                n_fail = 1'b0;
                if (r_a == '0) begin
                    n_state = msqrt_pkg::ST_FINISH;
                    n_r = '0;
                end else begin
                    n_q = w_pm1 >> w_s; n_m = w_s;
                    n_acc = w_one; n_sq = r_gen; n_exp = w_pm1 >> w_s;
                    n_state = msqrt_pkg::ST_TS_C_MUL;
                end
            end
            msqrt_pkg::ST_LOOP_CHK: begin
                if (r_t == w_one) begin
                    n_state = msqrt_pkg::ST_VERIFY;
                end else begin
                    n_acc = r_t; n_i = '0;
                    n_state = msqrt_pkg::ST_FIND_SQ;
                end
            end
            msqrt_pkg::ST_FIND_SQ: begin
                if (r_acc == w_one || r_i >= r_m) begin
                    n_cnt = '0;
                    if (r_i == '0 || r_i >= r_m) begin
                        n_fail = 1'b1; n_state = msqrt_pkg::ST_FINISH;
                    end else begin
                        n_b = r_c;
                        n_exp = W'(r_m - r_i - 1'b1);
                        n_state = msqrt_pkg::ST_B_SQ;
                    end
                end else if (w_done) begin
                    n_acc = w_prod; n_i = r_i + 1'b1; n_cnt = '0;
                end
            end
            msqrt_pkg::ST_B_SQ: begin
                if (r_exp == '0) begin
                    n_cnt = '0; n_m = r_i;
                    n_state = msqrt_pkg::ST_C_SQ;
                end else if (w_done) begin
                    n_b = w_prod; n_exp = r_exp - w_one; n_cnt = '0;
                end
            end
            msqrt_pkg::ST_C_SQ: begin
                if (w_done) begin
                    n_c = w_prod; n_cnt = '0; n_state = msqrt_pkg::ST_T_MUL;
                end
            end
            msqrt_pkg::ST_T_MUL: begin
                if (w_done) begin
                    n_t = w_prod; n_cnt = '0; n_state = msqrt_pkg::ST_R_MUL;
                end
            end
            msqrt_pkg::ST_R_MUL: begin
                if (w_done) begin
                    n_r = w_prod; n_cnt = '0; n_state = msqrt_pkg::ST_LOOP_CHK;
                end
            end
            msqrt_pkg::ST_VERIFY: begin
                if (w_done) begin
                    n_cnt = '0;
                    n_fail = (w_prod != r_a);
                    n_state = msqrt_pkg::ST_FINISH;
                end
            end
            msqrt_pkg::ST_FINISH: begin
                n_res = r_qr;
                if (r_fail || r_r == '0) n_root = '0;
                else if (w_pr < r_r)     n_root = w_pr;
                else                     n_root = r_r;
                n_state = msqrt_pkg::ST_OUT;
            end
            msqrt_pkg::ST_OUT: begin
                if (m_axis_tready) n_state = msqrt_pkg::ST_IDLE;
            end
            default: n_state = msqrt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msqrt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_a <= n_a; r_gen <= n_gen; r_acc <= n_acc; r_sq <= n_sq; r_exp <= n_exp;
        r_c <= n_c; r_t <= n_t; r_r <= n_r; r_b <= n_b; r_q <= n_q;
        r_rem <= n_rem; r_div <= n_div; r_m <= n_m; r_i <= n_i;
        r_qr <= n_qr; r_fail <= n_fail; r_root <= n_root; r_res <= n_res;
    end

    // Output decode.
    always_comb begin
        s_axis_tready = (r_state == msqrt_pkg::ST_IDLE);
        m_axis_tvalid = (r_state == msqrt_pkg::ST_OUT);
        m_axis_tdata  = {2'b00, r_root};
        m_axis_tuser  = r_res;
    end

endmodule

/* hdl/msqrt_mulmod.sv */
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
module msqrt_mulmod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [msqrt_pkg::Width-1:0]       i_x,
    input  logic [msqrt_pkg::Width-1:0]       i_y,
    input  logic [msqrt_pkg::Width-1:0]       i_m,
    output logic                              o_done,
    output logic [msqrt_pkg::Width-1:0]       o_prod
);

    logic [msqrt_pkg::Width-1:0] r_acc, n_acc;
    logic [msqrt_pkg::Width-1:0] r_y, n_y;
    logic [msqrt_pkg::CntW-1:0]  r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [msqrt_pkg::Width:0]   w_dbl, w_dbl_m, w_add, w_add_m;
    logic [msqrt_pkg::Width-1:0] w_d;

    // Each step doubles the accumulator and adds x when the next bit is set.
    always_comb begin
        w_dbl   = {r_acc, 1'b0};
        w_dbl_m = w_dbl - {1'b0, i_m};
        w_d     = w_dbl_m[msqrt_pkg::Width] ? w_dbl[msqrt_pkg::Width-1:0]
                                            : w_dbl_m[msqrt_pkg::Width-1:0];
        w_add   = {1'b0, w_d} + {1'b0, i_x};
        w_add_m = w_add - {1'b0, i_m};
    end

    always_comb begin
        n_acc  = r_acc;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_y    = i_y;
            n_cnt  = msqrt_pkg::CntW'(msqrt_pkg::Width);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y[msqrt_pkg::Width-1]) begin
                n_acc = w_add_m[msqrt_pkg::Width] ? w_add[msqrt_pkg::Width-1:0]
                                                  : w_add_m[msqrt_pkg::Width-1:0];
            end else begin
                n_acc = w_d;
            end
            n_y   = {r_y[msqrt_pkg::Width-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == msqrt_pkg::CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_y   <= n_y;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* hdl/msqrt_checker.sv */
// Port-level checker for the modular square root block, bound to the top level.
module msqrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while result pending");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken during work");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:62] == 2'b00)
        else $error("padding bits set");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind modular_square_root_with_fallback_core msqrt_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
